FILE: rtl/core/tcj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcj_pkg
// Shared constants, types and lookup tables of the thermocouple cold-junction
// compensation block.
// ----------------------------------------------------------------------------
package tcj_pkg;

  localparam int NTC_POINTS = 25;
  localparam int TC_POINTS  = 30;
  localparam int IDX_W      = 5;
  localparam int TBL_W      = 18;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int DIVD_W     = 33;
  localparam int DIVS_W     = 16;
  localparam int MUL_W      = 18;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int QUO_W      = DIVD_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_AMP_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_MV      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_OHMS = 2'd2;

  localparam logic [IDX_W-1:0] NTC_LAST = IDX_W'(NTC_POINTS - 2);
  localparam logic [IDX_W-1:0] TC_LAST  = IDX_W'(TC_POINTS - 2);

  // Request and status between the sequencer and the serial divider.
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
    logic              neg;
  } tcj_div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quotient;
  } tcj_div_rsp_t;

  // NTC resistance in ohms, descending.
  function automatic logic signed [TBL_W-1:0] ntc_ohm_f(input logic [IDX_W-1:0] i);
    logic signed [TBL_W-1:0] v;
    case (i)
      5'd0:  v = 18'sd68915;  5'd1:  v = 18'sd54166;  5'd2:  v = 18'sd42889;
      5'd3:  v = 18'sd34196;  5'd4:  v = 18'sd27445;  5'd5:  v = 18'sd22165;
      5'd6:  v = 18'sd18010;  5'd7:  v = 18'sd14720;  5'd8:  v = 18'sd12099;
      5'd9:  v = 18'sd10000;  5'd10: v = 18'sd8308;   5'd11: v = 18'sd6939;
      5'd12: v = 18'sd5824;   5'd13: v = 18'sd4911;   5'd14: v = 18'sd4160;
      5'd15: v = 18'sd3540;   5'd16: v = 18'sd3023;   5'd17: v = 18'sd2593;
      5'd18: v = 18'sd2232;   5'd19: v = 18'sd1929;   5'd20: v = 18'sd1672;
      5'd21: v = 18'sd1455;   5'd22: v = 18'sd1270;   5'd23: v = 18'sd1111;
      5'd24: v = 18'sd976;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Cold-junction temperature at each NTC point, 0.01 degC.
  function automatic logic signed [TBL_W-1:0] ntc_centi_f(input logic [IDX_W-1:0] i);
    logic signed [TBL_W-1:0] v;
    v = TBL_W'(18'sd500 * $signed({1'b0, i}) - 18'sd2000);
    return v;
  endfunction

  // K-type temperature points, 0.01 degC.
  function automatic logic signed [TBL_W-1:0] tc_centi_f(input logic [IDX_W-1:0] i);
    logic signed [TBL_W-1:0] v;
    case (i)
      5'd0:  v = -18'sd27000; 5'd1:  v = -18'sd8000;  5'd2:  v = -18'sd6000;
      5'd3:  v = -18'sd4000;  5'd4:  v = -18'sd2000;  5'd5:  v = 18'sd0;
      5'd6:  v = 18'sd2000;   5'd7:  v = 18'sd4000;   5'd8:  v = 18'sd6000;
      5'd9:  v = 18'sd8000;   5'd10: v = 18'sd10000;  5'd11: v = 18'sd12000;
      5'd12: v = 18'sd14000;  5'd13: v = 18'sd16000;  5'd14: v = 18'sd18000;
      5'd15: v = 18'sd20000;  5'd16: v = 18'sd25000;  5'd17: v = 18'sd30000;
      5'd18: v = 18'sd35000;  5'd19: v = 18'sd40000;  5'd20: v = 18'sd45000;
      5'd21: v = 18'sd50000;  5'd22: v = 18'sd55000;  5'd23: v = 18'sd60000;
      5'd24: v = 18'sd65000;  5'd25: v = 18'sd70000;  5'd26: v = 18'sd80000;
      5'd27: v = 18'sd90000;  5'd28: v = 18'sd100000; 5'd29: v = 18'sd120000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // K-type thermoelectric voltage points, microvolts.
  function automatic logic signed [TBL_W-1:0] tc_micro_f(input logic [IDX_W-1:0] i);
    logic signed [TBL_W-1:0] v;
    case (i)
      5'd0:  v = -18'sd6458;  5'd1:  v = -18'sd2920;  5'd2:  v = -18'sd2243;
      5'd3:  v = -18'sd1527;  5'd4:  v = -18'sd778;   5'd5:  v = 18'sd0;
      5'd6:  v = 18'sd798;    5'd7:  v = 18'sd1612;   5'd8:  v = 18'sd2436;
      5'd9:  v = 18'sd3267;   5'd10: v = 18'sd4096;   5'd11: v = 18'sd4920;
      5'd12: v = 18'sd5735;   5'd13: v = 18'sd6540;   5'd14: v = 18'sd7340;
      5'd15: v = 18'sd8138;   5'd16: v = 18'sd10153;  5'd17: v = 18'sd12209;
      5'd18: v = 18'sd14293;  5'd19: v = 18'sd16397;  5'd20: v = 18'sd18516;
      5'd21: v = 18'sd20644;  5'd22: v = 18'sd22776;  5'd23: v = 18'sd24905;
      5'd24: v = 18'sd27025;  5'd25: v = 18'sd29129;  5'd26: v = 18'sd33275;
      5'd27: v = 18'sd37326;  5'd28: v = 18'sd41276;  5'd29: v = 18'sd48838;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/tcj_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcj_if
// Valid/ready channels for the reading and result transactions.
// ----------------------------------------------------------------------------
interface tcj_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] amp_millivolts;
  logic [15:0] ntc_millivolts;

  modport source (output valid, amp_millivolts, ntc_millivolts, input ready);
  modport sink   (input valid, amp_millivolts, ntc_millivolts, output ready);
endinterface

interface tcj_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] hot_temp_centi;
  logic signed [14:0] cold_temp_centi;
  logic               out_of_range;

  modport source (output valid, hot_temp_centi, cold_temp_centi, out_of_range,
                  input ready);
  modport sink   (input valid, hot_temp_centi, cold_temp_centi, out_of_range,
                  output ready);
endinterface

FILE: rtl/core/tcj_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcj_mul
// Shared signed 18x18 multiplier with a registered product.
// ----------------------------------------------------------------------------
module tcj_mul (
  input  logic                             clk_i,
  input  logic signed [tcj_pkg::MUL_W-1:0]  a_i,
  input  logic signed [tcj_pkg::MUL_W-1:0]  b_i,
  output logic signed [tcj_pkg::PROD_W-1:0] prod_o
);
  import tcj_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // Product register; operands are held stable by the sequencer.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/core/tcj_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcj_div
// Shared restoring divider, one quotient bit per cycle, with sign fix-up.
// ----------------------------------------------------------------------------
module tcj_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcj_pkg::tcj_div_req_t req_i,
  output tcj_pkg::tcj_div_rsp_t rsp_o
);
  import tcj_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] dsr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q, neg_q;
  logic [DIVS_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift the dividend through the partial remainder.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      rem_q <= fits ? DIVS_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

FILE: rtl/core/thermocouple_cold_junction_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermocouple_cold_junction_temp
// Hot-junction temperature of a K-type thermocouple with NTC cold-junction
// compensation, computed by a sequencer around one multiplier and one divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one reading transaction (amplified thermocouple mV and NTC
//   divider mV); out_o returns one result transaction per reading:
//   hot and cold temperatures in 0.01 degC and an out-of-range flag.
//   The cfg_* port writes gain, reference voltage and series resistor; write
//   it only while no reading is in flight.
//   A reading takes five multiply/divide passes (a multiply, a divider
//   load and the serial quotient bits) plus three table searches that try
//   one segment at a time, and then the result is loaded.
//   A reading whose NTC voltage is at or above the reference skips the
//   passes and goes straight to the result, flagged out of range.
//   in_i.ready is high only while the sequencer is idle; one reading is
//   worked on at a time.
//   The result sits in an output register; a stalled receiver does not stop
//   the next reading from being taken, but a finished result waits until the
//   register frees.
//   Reset restores the register defaults (gain 100, 2800 mV, 10000 ohms) and
//   empties the output register.
// ----------------------------------------------------------------------------
module thermocouple_cold_junction_temp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcj_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcj_pkg::CFG_W-1:0]      cfg_data_i,
  tcj_in_if.sink                         in_i,
  tcj_out_if.source                      out_o
);
  import tcj_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIVS, ST_DIVW, ST_SRCH, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    OP_R, OP_NTC, OP_TA, OP_U, OP_TB
  } op_e;

  localparam int XW = 27;

  state_e state_q;
  op_e    op_q;

  logic [9:0]  gain_q;
  logic [12:0] ref_q;
  logic [16:0] series_q;

  logic [15:0]             amp_q, ntc_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [XW-1:0]    x_q;
  logic signed [TBL_W-1:0] y0_q, dy_q, dx_q, comp_q, cold_q, hot_q;
  logic [DIVS_W-1:0]       dmag_q;
  logic                    dneg_q, flag_q;

  logic                    out_valid_q, out_flag_q;
  logic signed [17:0]      out_hot_q;
  logic signed [14:0]      out_cold_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= 10'd100;
      ref_q    <= 13'd2800;
      series_q <= 17'd10000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AMP_GAIN:    gain_q   <= cfg_data_i[9:0];
        CFG_REF_MV:      ref_q    <= cfg_data_i[12:0];
        CFG_SERIES_OHMS: series_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table segment under test.
  logic [IDX_W-1:0]        idx_nx;
  logic signed [TBL_W-1:0] tx0, tx1, ty0, ty1;
  logic signed [XW-1:0]    x0e, x1e;
  logic                    hit, last;
  logic signed [TBL_W-1:0] seg_d;

  assign idx_nx = idx_q + 1'b1;

  always_comb begin
    case (op_q)
      OP_NTC: begin
        tx0 = ntc_ohm_f(idx_q);   tx1 = ntc_ohm_f(idx_nx);
        ty0 = ntc_centi_f(idx_q); ty1 = ntc_centi_f(idx_nx);
      end
      OP_TA: begin
        tx0 = tc_centi_f(idx_q);  tx1 = tc_centi_f(idx_nx);
        ty0 = tc_micro_f(idx_q);  ty1 = tc_micro_f(idx_nx);
      end
      default: begin
        tx0 = tc_micro_f(idx_q);  tx1 = tc_micro_f(idx_nx);
        ty0 = tc_centi_f(idx_q);  ty1 = tc_centi_f(idx_nx);
      end
    endcase
  end

  assign x0e   = XW'(tx0);
  assign x1e   = XW'(tx1);
  assign seg_d = tx1 - tx0;
  assign last  = (op_q == OP_NTC) ? (idx_q == NTC_LAST) : (idx_q == TC_LAST);
  // NTC resistances fall along the table; the first point whose successor is
  // below the value bounds the segment (the last one extrapolates).
  assign hit   = (op_q == OP_NTC) ? ((x1e < x_q) || last)
                                  : ((x0e <= x_q) && (x_q <= x1e));

  // Shared multiplier operands.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    case (op_q)
      OP_R: begin
        mul_a = $signed({2'b00, ntc_q});
        mul_b = $signed({1'b0, series_q});
      end
      OP_U: begin
        mul_a = $signed({2'b00, amp_q});
        mul_b = 18'sd1000;
      end
      default: begin
        mul_a = dy_q;
        mul_b = dx_q;
      end
    endcase
  end

  tcj_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Shared divider request.
  tcj_div_req_t          div_req;
  tcj_div_rsp_t          div_rsp;
  logic [PROD_W-1:0]     prod_abs;

  assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  always_comb begin
    div_req.start    = (state_q == ST_DIVS);
    div_req.dividend = prod_abs[DIVD_W-1:0];
    case (op_q)
      OP_R: begin
        div_req.divisor = DIVS_W'(ref_q - ntc_q[12:0]);
        div_req.neg     = 1'b0;
      end
      OP_U: begin
        div_req.divisor = (gain_q == '0) ? DIVS_W'(1) : DIVS_W'(gain_q);
        div_req.neg     = 1'b0;
      end
      default: begin
        div_req.divisor = dmag_q;
        div_req.neg     = prod[PROD_W-1] ^ dneg_q;
      end
    endcase
  end

  tcj_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic signed [TBL_W-1:0] lerp_y;
  assign lerp_y = TBL_W'(div_rsp.quotient + QUO_W'(y0_q));

  // Sequencer with its working and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_R;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      flag_q      <= 1'b0;
      amp_q       <= '0;
      ntc_q       <= '0;
      x_q         <= '0;
      y0_q        <= '0;
      dy_q        <= '0;
      dx_q        <= '0;
      dmag_q      <= '0;
      dneg_q      <= 1'b0;
      comp_q      <= '0;
      cold_q      <= '0;
      hot_q       <= '0;
      out_hot_q   <= '0;
      out_cold_q  <= '0;
      out_flag_q  <= 1'b0;
    end else begin
      // The output register fills from the final state and empties on a handshake.
      if ((state_q == ST_FIN) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            amp_q  <= in_i.amp_millivolts;
            ntc_q  <= in_i.ntc_millivolts;
            cold_q <= '0;
            hot_q  <= '0;
            op_q   <= OP_R;
            if (in_i.ntc_millivolts >= 16'(ref_q)) begin
              flag_q  <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              flag_q  <= 1'b0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL:  state_q <= ST_DIVS;
        ST_DIVS: state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_rsp.done) begin
            idx_q <= '0;
            case (op_q)
              OP_R: begin
                x_q     <= (|div_rsp.quotient[DIVD_W-1:16]) ? XW'(65535)
                           : XW'($unsigned(div_rsp.quotient[15:0]));
                op_q    <= OP_NTC;
                state_q <= ST_SRCH;
              end
              OP_NTC: begin
                cold_q  <= lerp_y;
                x_q     <= XW'(lerp_y);
                op_q    <= OP_TA;
                state_q <= ST_SRCH;
              end
              OP_TA: begin
                comp_q  <= lerp_y;
                op_q    <= OP_U;
                state_q <= ST_MUL;
              end
              OP_U: begin
                x_q     <= XW'(div_rsp.quotient) + XW'(comp_q);
                op_q    <= OP_TB;
                state_q <= ST_SRCH;
              end
              default: begin
                hot_q   <= lerp_y;
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_SRCH: begin
          if (hit) begin
            y0_q    <= ty0;
            dy_q    <= ty1 - ty0;
            dx_q    <= TBL_W'(x_q - x0e);
            dneg_q  <= seg_d[TBL_W-1];
            dmag_q  <= seg_d[TBL_W-1] ? DIVS_W'(-seg_d) : DIVS_W'(seg_d);
            state_q <= ST_MUL;
          end else if (last) begin
            // Value lies outside the K-type table.
            flag_q  <= 1'b1;
            hot_q   <= '0;
            state_q <= ST_FIN;
          end else begin
            idx_q <= idx_nx;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_hot_q   <= hot_q;
            out_cold_q  <= cold_q[14:0];
            out_flag_q  <= flag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.hot_temp_centi  = out_hot_q;
  assign out_o.cold_temp_centi = out_cold_q;
  assign out_o.out_of_range    = out_flag_q;

endmodule
